// File: src/assert_macros.svh
// Assertion helpers, included only by the top-level RTL file to check itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold on the following clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: src/wsd_pkg.sv
`timescale 1ns / 1ps

package wsd_pkg;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam logic [6:0] LEN_CODE_SHORT_MAX = 7'd125;
	localparam logic [6:0] LEN_CODE_EXT16     = 7'd126;

	localparam int TDATA_W = 88;

	// Parser phase, one-hot.
	typedef enum logic [4:0] {
		PH_FLAGS   = 5'b00001,
		PH_LENCODE = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_KEY     = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// One classified transaction handed from the parser to the output side.
	// flags: [8] FIN, [7:5] RSV1..RSV3, [4:1] opcode, [0] MASK.
	typedef struct packed {
		logic        kind;
		logic        last;
		logic [7:0]  data;
		logic [8:0]  flags;
		logic [63:0] length;
		logic [31:0] key;
	} entry_t;

endpackage

// File: src/wsd_front.sv
`timescale 1ns / 1ps

module wsd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	output logic            push_valid,
	input  logic            push_ready,
	output wsd_pkg::entry_t push_entry
);

	wsd_pkg::phase_t phase_q, phase_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [8:0]  flags_q, flags_n;
	logic [63:0] len_q, len_n;
	logic [63:0] rem_q, rem_n;
	logic [31:0] key_q, key_n;
	logic        ext_long_q, ext_long_n;
	logic        accept;
	logic        finish;
	logic        emit;
	logic        last;

	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;
	assign push_valid = accept && emit;

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		flags_n    = flags_q;
		len_n      = len_q;
		rem_n      = rem_q;
		key_n      = key_q;
		ext_long_n = ext_long_q;
		finish     = 1'b0;
		emit       = 1'b0;
		last       = 1'b0;
		case (phase_q)
			wsd_pkg::PH_LENCODE: begin
				flags_n = {flags_q[8:1], in_byte[7]};
				key_n   = '0;
				cnt_n   = '0;
				if (in_byte[6:0] <= wsd_pkg::LEN_CODE_SHORT_MAX) begin
					len_n = {57'd0, in_byte[6:0]};
					if (in_byte[7])
						phase_n = wsd_pkg::PH_KEY;
					else
						finish = 1'b1;
				end else begin
					len_n      = '0;
					ext_long_n = (in_byte[6:0] != wsd_pkg::LEN_CODE_EXT16);
					phase_n    = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				len_n = {len_q[55:0], in_byte};
				cnt_n = cnt_q + 4'd1;
				if (cnt_n >= (ext_long_q ? 4'd8 : 4'd2)) begin
					cnt_n = '0;
					if (flags_q[0])
						phase_n = wsd_pkg::PH_KEY;
					else
						finish = 1'b1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_n = {key_q[23:0], in_byte};
				cnt_n = cnt_q + 4'd1;
				if (cnt_n >= 4'd4)
					finish = 1'b1;
			end
			wsd_pkg::PH_PAYLOAD: begin
				emit  = 1'b1;
				last  = (rem_q == 64'd1);
				rem_n = rem_q - 64'd1;
				if (last)
					phase_n = wsd_pkg::PH_FLAGS;
			end
			default: begin
				// PH_FLAGS and invalid codes parse the byte as a first header byte.
				flags_n = {in_byte[7:4], in_byte[3:0], 1'b0};
				cnt_n   = '0;
				phase_n = wsd_pkg::PH_LENCODE;
			end
		endcase
		if (finish) begin
			emit    = 1'b1;
			cnt_n   = '0;
			rem_n   = len_n;
			phase_n = (len_n == 64'd0) ? wsd_pkg::PH_FLAGS : wsd_pkg::PH_PAYLOAD;
		end
	end

	always_comb begin
		push_entry.kind   = finish ? wsd_pkg::KIND_HEADER : wsd_pkg::KIND_PAYLOAD;
		push_entry.last   = last;
		push_entry.data   = finish ? 8'd0 : in_byte;
		push_entry.flags  = flags_n;
		push_entry.length = len_n;
		push_entry.key    = key_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsd_pkg::PH_FLAGS;
			cnt_q      <= '0;
			flags_q    <= '0;
			len_q      <= '0;
			rem_q      <= '0;
			key_q      <= '0;
			ext_long_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_n;
			cnt_q      <= cnt_n;
			flags_q    <= flags_n;
			len_q      <= len_n;
			rem_q      <= rem_n;
			key_q      <= key_n;
			ext_long_q <= ext_long_n;
		end
	end

endmodule

// File: src/wsd_queue.sv
`timescale 1ns / 1ps

module wsd_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wsd_pkg::entry_t in_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output wsd_pkg::entry_t out_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsd_pkg::entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= in_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: src/wsd_back.sv
`timescale 1ns / 1ps

module wsd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pop_valid,
	output logic                        pop_ready,
	input  wsd_pkg::entry_t             pop_entry,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wsd_pkg::TDATA_W-1:0] out_data,
	output logic                        out_user,
	output logic                        out_last
);

	logic [1:0] key_idx_q;
	logic       valid_q;
	logic       kind_q;
	logic       last_q;
	logic [wsd_pkg::TDATA_W-1:0] data_q;
	logic [7:0] key_byte;
	logic [7:0] plain;
	logic       take;

	assign pop_ready = !valid_q || out_ready;
	assign take      = pop_valid && pop_ready;

	// Key bytes are applied in wire order: index 0 uses the first key byte.
	assign key_byte = pop_entry.key[{~key_idx_q, 3'b000} +: 8];
	assign plain    = (pop_entry.kind == wsd_pkg::KIND_PAYLOAD) ?
		(pop_entry.data ^ key_byte) : 8'd0;

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= pop_entry.kind;
			last_q <= pop_entry.last;
			data_q <= {7'd0, plain, pop_entry.length, pop_entry.flags[0],
				pop_entry.flags[4:1], pop_entry.flags[7:5], pop_entry.flags[8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			key_idx_q <= '0;
		end else begin
			if (take)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
			if (take) begin
				if (pop_entry.kind == wsd_pkg::KIND_HEADER)
					key_idx_q <= '0;
				else
					key_idx_q <= key_idx_q + 2'd1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = kind_q;
	assign out_last  = last_q;

endmodule

// File: src/websocket_frame_deframer.sv
// Channel   Direction  Signals                       Carries
// s_*       in         s_tvalid, s_tready, s_tdata    one received byte per transaction
// m_*       out        m_tvalid, m_tready, m_tdata,   one header or unmasked payload byte
//                      m_tuser, m_tlast
//
// One byte is accepted per cycle; s_tready drops only when the queue is full. A result
// is queued as its byte is accepted, then registered at the output. The parser updates
// its state once per byte; header bytes that give no result push nothing. The queue
// lets the parser run on while the output stalls. arst_n clears parser, queue and output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [0] fin_flag, [3:1] reserved_bits, [7:4] opcode, [8] masked,
	// [72:9] payload_length, [80:73] data_byte, [87:81] zero
	output logic [wsd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tuser,   // [0] kind
	output logic                        m_tlast    // last_of_payload
);

	logic            push_valid, push_ready;
	wsd_pkg::entry_t push_entry;
	logic            q_valid, q_ready;
	wsd_pkg::entry_t q_entry;

	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_entry  (push_entry),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_entry (q_entry)
	);

	wsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_entry (q_entry),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

	`ASSERT_CLK(a_hdr_no_data,
		(m_tvalid && m_tuser == wsd_pkg::KIND_HEADER) |-> (!m_tlast && m_tdata[80:73] == 8'd0),
		"header result carries payload data or last flag")
	`ASSERT_CLK(a_last_is_payload,
		(m_tvalid && m_tlast) |-> (m_tuser == wsd_pkg::KIND_PAYLOAD),
		"last flag on a non-payload result")
	`ASSERT_NEXT(a_hdr_pop_out,
		q_valid && q_ready && q_entry.kind == wsd_pkg::KIND_HEADER,
		m_tvalid && m_tuser == wsd_pkg::KIND_HEADER,
		"popped header did not reach the output register")

endmodule

// File: tb/websocket_frame_deframer_test.sv
`timescale 1ns / 1ps

module websocket_frame_deframer_test;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_BYTES = 1300;
	localparam int STALL_CYCLES = 300;
	localparam int DIRECTED_ROWS = 25;

	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	localparam logic [3:0] OP_CONTINUATION = 4'h0;
	localparam logic [3:0] OP_TEXT = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;

	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [7:0]  data;
		logic        last;
	} deframe_result_t;

	typedef struct packed {
		logic [7:0]      rx;
		bit              typed;
		bit              has_res;
		deframe_result_t res;
	} stim_row_t;

	localparam deframe_result_t NO_RESULT = '0;

	// Rows with typed = 0 take their expectation from the predictor.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Zero-length text frame right after reset: header only.
		'{8'h81, 1'b1, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1,
			'{wsd_pkg::KIND_HEADER, 1'b1, 3'd0, OP_TEXT, 1'b0, 64'd0, 8'h00, 1'b0}},
		// Masked two-byte frame with all RSV bits set.
		'{8'hF2, 1'b0, 1'b0, NO_RESULT},
		'{8'h82, 1'b0, 1'b0, NO_RESULT},
		'{8'hAA, 1'b0, 1'b0, NO_RESULT},
		'{8'h55, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1,
			'{wsd_pkg::KIND_HEADER, 1'b1, 3'd7, OP_BINARY, 1'b1, 64'd2, 8'h00, 1'b0}},
		'{8'h0F, 1'b1, 1'b1,
			'{wsd_pkg::KIND_PAYLOAD, 1'b1, 3'd7, OP_BINARY, 1'b1, 64'd2, 8'hA5, 1'b0}},
		'{8'hF0, 1'b1, 1'b1,
			'{wsd_pkg::KIND_PAYLOAD, 1'b1, 3'd7, OP_BINARY, 1'b1, 64'd2, 8'hA5, 1'b1}},
		// 16-bit extended length that encodes zero.
		'{8'h08, 1'b0, 1'b0, NO_RESULT},
		'{8'h7E, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1,
			'{wsd_pkg::KIND_HEADER, 1'b0, 3'd0, OP_CLOSE, 1'b0, 64'd0, 8'h00, 1'b0}},
		// 64-bit extended length of one, unmasked.
		'{8'h80, 1'b0, 1'b0, NO_RESULT},
		'{8'h7F, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b1, 1'b1,
			'{wsd_pkg::KIND_HEADER, 1'b1, 3'd0, OP_CONTINUATION, 1'b0, 64'd1, 8'h00,
				1'b0}},
		'{8'hFF, 1'b1, 1'b1,
			'{wsd_pkg::KIND_PAYLOAD, 1'b1, 3'd0, OP_CONTINUATION, 1'b0, 64'd1, 8'hFF,
				1'b1}}
	};

	logic                        clk;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [7:0]                  s_tdata;
	logic                        m_tvalid;
	logic                        m_tready;
	logic [wsd_pkg::TDATA_W-1:0] m_tdata;
	logic                        m_tuser;
	logic                        m_tlast;

	websocket_frame_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Parser state mirrored by the predictor.
	wsd_pkg::phase_t parse_phase;
	logic [3:0]  hdr_count;
	logic [3:0]  ext_bytes;
	logic [8:0]  frame_flags;
	logic [63:0] decoded_len;
	logic [63:0] bytes_left;
	logic [31:0] mask_key;
	logic [1:0]  key_index;

	deframe_result_t pending_results[$];

	// Expectation attached to the byte currently offered on the input.
	bit              offer_typed;
	bit              offer_has_res;
	deframe_result_t offer_res;

	int errors;
	int cycles;
	int bytes_sent;
	int results_seen;
	int headers_seen;
	int payload_seen;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic deframe_result_t frame_fields(input logic kind);
		deframe_result_t r;
		r = '0;
		r.kind = kind;
		r.fin = frame_flags[8];
		r.rsv = frame_flags[7:5];
		r.opcode = frame_flags[4:1];
		r.masked = frame_flags[0];
		r.length = decoded_len;
		return r;
	endfunction

	function automatic bit header_done(output deframe_result_t r);
		r = frame_fields(wsd_pkg::KIND_HEADER);
		key_index = '0;
		hdr_count = '0;
		bytes_left = decoded_len;
		parse_phase = (decoded_len == 64'd0) ? wsd_pkg::PH_FLAGS : wsd_pkg::PH_PAYLOAD;
		return 1'b1;
	endfunction

	function automatic bit length_done(output deframe_result_t r);
		r = '0;
		hdr_count = '0;
		if (frame_flags[0]) begin
			parse_phase = wsd_pkg::PH_KEY;
			return 1'b0;
		end
		return header_done(r);
	endfunction

	// Advances the parser model by one received byte; returns 1 when a result is due.
	function automatic bit deframe_byte(input logic [7:0] b, output deframe_result_t r);
		logic [7:0] key_byte;
		bit produced;
		produced = 1'b0;
		r = '0;
		case (parse_phase)
			wsd_pkg::PH_LENCODE: begin
				frame_flags[0] = b[7];
				mask_key = '0;
				decoded_len = '0;
				hdr_count = '0;
				if (b[6:0] <= wsd_pkg::LEN_CODE_SHORT_MAX) begin
					decoded_len = 64'(b[6:0]);
					produced = length_done(r);
				end else begin
					ext_bytes = (b[6:0] == wsd_pkg::LEN_CODE_EXT16) ? 4'd2 : 4'd8;
					parse_phase = wsd_pkg::PH_EXTLEN;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				decoded_len = {decoded_len[55:0], b};
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= ext_bytes)
					produced = length_done(r);
			end
			wsd_pkg::PH_KEY: begin
				mask_key = {mask_key[23:0], b};
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= 4'd4)
					produced = header_done(r);
			end
			wsd_pkg::PH_PAYLOAD: begin
				// Key bytes are applied in the order they arrived on the wire.
				key_byte = mask_key[31 - 8 * key_index -: 8];
				r = frame_fields(wsd_pkg::KIND_PAYLOAD);
				r.data = b ^ key_byte;
				key_index = key_index + 2'd1;
				bytes_left = bytes_left - 64'd1;
				if (bytes_left == 64'd0) begin
					r.last = 1'b1;
					parse_phase = wsd_pkg::PH_FLAGS;
				end
				produced = 1'b1;
			end
			default: begin
				frame_flags = {b[7:4], b[3:0], 1'b0};
				hdr_count = '0;
				parse_phase = wsd_pkg::PH_LENCODE;
			end
		endcase
		return produced;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: mismatch in %s: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, pending_results.size());
			$display("websocket_frame_deframer regression: fail");
			$finish;
		end
	end

	// Input transactions feed the predictor first, so an output in the same edge
	// is always compared against a complete queue.
	always @(posedge clk) begin
		deframe_result_t pred;
		deframe_result_t want;
		bit produced;
		if (arst_n && s_tvalid && s_tready) begin
			produced = deframe_byte(s_tdata, pred);
			if (offer_typed) begin
				if (offer_has_res)
					pending_results.push_back(offer_res);
			end else if (produced) begin
				pending_results.push_back(pred);
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser == wsd_pkg::KIND_HEADER)
				headers_seen++;
			else
				payload_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tdata %h tuser %b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_tuser));
				check_field("fin_flag", 64'(want.fin), 64'(m_tdata[0]));
				check_field("reserved_bits", 64'(want.rsv), 64'(m_tdata[3:1]));
				check_field("opcode", 64'(want.opcode), 64'(m_tdata[7:4]));
				check_field("masked", 64'(want.masked), 64'(m_tdata[8]));
				check_field("payload_length", want.length, m_tdata[72:9]);
				check_field("data_byte", 64'(want.data), 64'(m_tdata[80:73]));
				check_field("last_of_payload", 64'(want.last), 64'(m_tlast));
				check_field("tdata padding", 64'd0, 64'(m_tdata[87:81]));
			end
		end
	end

	// Output side: random ready pattern plus one long hold-off to fill the block.
	initial begin
		int hold;
		int r;
		bit stalled_once;
		hold = 0;
		stalled_once = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!stalled_once && results_seen >= 150) begin
				stalled_once = 1'b1;
				m_tready = 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
			end
			if (hold > 0) begin
				hold--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					m_tready = 1'b1;
					hold = $urandom_range(0, 20);
				end else if (r < 95) begin
					m_tready = 1'b0;
					hold = $urandom_range(0, 3);
				end else begin
					m_tready = 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_byte(input logic [7:0] b, input bit no_gaps = 1'b0,
			input bit typed = 1'b0, input bit has_res = 1'b0,
			input deframe_result_t res = '0);
		int r;
		int gap;
		gap = 0;
		if (!no_gaps) begin
			r = $urandom_range(0, 99);
			if (r >= 95)
				gap = $urandom_range(10, 40);
			else if (r >= 70)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		offer_typed = typed;
		offer_has_res = has_res;
		offer_res = res;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Mostly short frames; extended lengths stay small so the run keeps moving.
	task automatic send_frame(input bit no_gaps);
		logic [7:0] head;
		logic [6:0] code;
		logic [63:0] len64;
		bit masked;
		int r;
		int len;
		head = 8'($urandom_range(0, 255));
		masked = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 55)
			len = $urandom_range(0, 12);
		else if (r < 70)
			len = $urandom_range(13, 125);
		else if (r < 88)
			len = $urandom_range(0, 40);
		else if (r < 92)
			len = $urandom_range(126, 300);
		else
			len = $urandom_range(0, 24);
		if (r < 70)
			code = 7'(len);
		else if (r < 92)
			code = wsd_pkg::LEN_CODE_EXT16;
		else
			code = LEN_CODE_EXT64;
		len64 = 64'(len);
		send_byte(head, no_gaps);
		send_byte({masked, code}, no_gaps);
		if (code == wsd_pkg::LEN_CODE_EXT16) begin
			send_byte(len64[15:8], no_gaps);
			send_byte(len64[7:0], no_gaps);
		end else if (code == LEN_CODE_EXT64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len64[8 * i +: 8], no_gaps);
		end
		if (masked)
			repeat (4) send_byte(8'($urandom_range(0, 255)), no_gaps);
		repeat (len) send_byte(8'($urandom_range(0, 255)), no_gaps);
	endtask

	initial begin
		parse_phase = wsd_pkg::PH_FLAGS;
		hdr_count = '0;
		ext_bytes = '0;
		frame_flags = '0;
		decoded_len = '0;
		bytes_left = '0;
		mask_key = '0;
		key_index = '0;
		errors = 0;
		cycles = 0;
		bytes_sent = 0;
		results_seen = 0;
		headers_seen = 0;
		payload_seen = 0;
		offer_typed = 1'b0;
		offer_has_res = 1'b0;
		offer_res = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i].rx, 1'b0, DIRECTED[i].typed, DIRECTED[i].has_res,
				DIRECTED[i].res);

		while (bytes_sent < RANDOM_BYTES)
			send_frame($urandom_range(0, 3) == 0);

		// Largest possible 64-bit length, masked; the run ends partway through it.
		send_byte(8'($urandom_range(0, 255)));
		send_byte({1'b1, LEN_CODE_EXT64});
		repeat (8) send_byte(8'hFF);
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		repeat (24) send_byte(8'($urandom_range(0, 255)));
		s_tvalid = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes; checked %0d headers and %0d payload bytes.",
			bytes_sent, headers_seen, payload_seen);
		$display("Frames used short, 16-bit and 64-bit lengths, with and without masking.");
		if (errors == 0) begin
			$display("websocket_frame_deframer regression: pass");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("websocket_frame_deframer regression: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/wsd_pkg.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
